// ===== hdl/wrp_pkg.sv =====
package wrp_pkg;

	// Field and register widths
	localparam int CX_W = 7;
	localparam int CY_W = 6;
	localparam int HS_W = 6;
	localparam int OUT_X_W = 9;
	localparam int OUT_Y_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 2'd2;

	// Register values after reset
	localparam logic [CX_W-1:0] RST_CENTER_X = 7'd64;
	localparam logic [CY_W-1:0] RST_CENTER_Y = 6'd32;
	localparam logic [HS_W-1:0] RST_HALF_SIZE = 6'd18;

	// Vertex path defaults
	localparam int VERTEX_COUNT = 16;
	localparam int CORNER_N = 16;

	// Angle ring: 48 steps of pi/24
	localparam int ANGLE_STEPS = 48;
	localparam int ANG_W = 6;
	localparam int QUARTER = ANGLE_STEPS / 4;
	localparam int HALF = ANGLE_STEPS / 2;
	localparam int THREE_Q = 3 * ANGLE_STEPS / 4;

	// Fixed-point widths: Q1.15 trig, operand, product and accumulator
	localparam int FRAC = 15;
	localparam int COEF_W = 17;
	localparam int YZ_W = 24;
	localparam int OPW = 40;
	localparam int ACC_W = OPW + COEF_W;
	localparam int ACC_SHIFT = 3 * FRAC;

	// Corner sign patterns, bit i set where vertex i sits at +half_size
	localparam logic [CORNER_N-1:0] CORNER_X_POS = 16'h87C6;
	localparam logic [CORNER_N-1:0] CORNER_Y_POS = 16'h219F;
	localparam logic [CORNER_N-1:0] CORNER_Z_POS = 16'h0CF3;

	// Sequencer program layout
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_TRIG = 4'd0;
	localparam logic [PC_W-1:0] PC_VTX = 4'd1;

	// Control word fields
	typedef enum logic [2:0] {
		MS_NONE,
		MS_X0SH,
		MS_Y0,
		MS_Z0,
		MS_Y1SH,
		MS_Z1,
		MS_X2
	} msrc_t;

	typedef enum logic {
		CF_SIN,
		CF_COS
	} coef_t;

	typedef enum logic [2:0] {
		AO_NOP,
		AO_LOAD,
		AO_ADD,
		AO_SUB,
		AO_RSUB
	} aop_t;

	typedef enum logic [2:0] {
		WS_NONE,
		WS_TRIG,
		WS_Y1,
		WS_Z1,
		WS_X2,
		WS_X3,
		WS_Y3
	} wsel_t;

	typedef enum logic {
		SQ_NEXT,
		SQ_EMIT
	} seq_t;

	typedef struct packed {
		msrc_t msrc;
		coef_t coef;
		aop_t aop;
		wsel_t wsel;
		seq_t seq;
	} uword_t;

	localparam uword_t UW_IDLE = '{MS_NONE, CF_SIN, AO_NOP, WS_NONE, SQ_NEXT};

	// Microprogram. The product register feeds the accumulator on the step after
	// the multiply, and a write stores the accumulator as it stood before that step's update.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = UW_IDLE;
		unique case (pc)
			4'd0: w = '{MS_NONE, CF_SIN, AO_NOP, WS_TRIG, SQ_NEXT};
			4'd1: w = '{MS_Y0, CF_COS, AO_NOP, WS_NONE, SQ_NEXT};
			4'd2: w = '{MS_Z0, CF_SIN, AO_LOAD, WS_NONE, SQ_NEXT};
			4'd3: w = '{MS_Y0, CF_SIN, AO_SUB, WS_NONE, SQ_NEXT};
			4'd4: w = '{MS_Z0, CF_COS, AO_LOAD, WS_Y1, SQ_NEXT};
			4'd5: w = '{MS_X0SH, CF_COS, AO_ADD, WS_NONE, SQ_NEXT};
			4'd6: w = '{MS_NONE, CF_SIN, AO_LOAD, WS_Z1, SQ_NEXT};
			4'd7: w = '{MS_Z1, CF_SIN, AO_NOP, WS_NONE, SQ_NEXT};
			4'd8: w = '{MS_NONE, CF_SIN, AO_ADD, WS_NONE, SQ_NEXT};
			4'd9: w = '{MS_Y1SH, CF_SIN, AO_NOP, WS_X2, SQ_NEXT};
			4'd10: w = '{MS_X2, CF_COS, AO_LOAD, WS_NONE, SQ_NEXT};
			4'd11: w = '{MS_X2, CF_SIN, AO_RSUB, WS_NONE, SQ_NEXT};
			4'd12: w = '{MS_Y1SH, CF_COS, AO_LOAD, WS_X3, SQ_NEXT};
			4'd13: w = '{MS_NONE, CF_SIN, AO_ADD, WS_NONE, SQ_NEXT};
			4'd14: w = '{MS_NONE, CF_SIN, AO_NOP, WS_Y3, SQ_NEXT};
			4'd15: w = '{MS_NONE, CF_SIN, AO_NOP, WS_NONE, SQ_EMIT};
			default: w = UW_IDLE;
		endcase
		return w;
	endfunction

	// First quadrant of the sine table, Q1.15
	function automatic logic signed [COEF_W-1:0] sin_base(input logic [3:0] j);
		logic signed [COEF_W-1:0] v;
		case (j)
			4'd0: v = 17'sd0;
			4'd1: v = 17'sd4277;
			4'd2: v = 17'sd8481;
			4'd3: v = 17'sd12540;
			4'd4: v = 17'sd16384;
			4'd5: v = 17'sd19948;
			4'd6: v = 17'sd23170;
			4'd7: v = 17'sd25997;
			4'd8: v = 17'sd28378;
			4'd9: v = 17'sd30274;
			4'd10: v = 17'sd31651;
			4'd11: v = 17'sd32488;
			4'd12: v = 17'sd32768;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

	// Full-circle sine by quadrant symmetry
	function automatic logic signed [COEF_W-1:0] sin_q15(input logic [ANG_W-1:0] k);
		logic [3:0] j;
		logic neg;
		if (k <= ANG_W'(QUARTER)) begin
			j = 4'(k);
			neg = 1'b0;
		end else if (k <= ANG_W'(HALF)) begin
			j = 4'(ANG_W'(HALF) - k);
			neg = 1'b0;
		end else if (k <= ANG_W'(THREE_Q)) begin
			j = 4'(k - ANG_W'(HALF));
			neg = 1'b1;
		end else begin
			j = 4'(ANG_W'(ANGLE_STEPS) - k);
			neg = 1'b1;
		end
		return neg ? -sin_base(j) : sin_base(j);
	endfunction

	// Cosine is the sine a quarter turn ahead
	function automatic logic [ANG_W-1:0] cos_index(input logic [ANG_W-1:0] k);
		logic [ANG_W:0] t;
		t = {1'b0, k} + (ANG_W+1)'(QUARTER);
		if (t >= (ANG_W+1)'(ANGLE_STEPS)) begin
			t = t - (ANG_W+1)'(ANGLE_STEPS);
		end
		return t[ANG_W-1:0];
	endfunction

endpackage

// ===== hdl/wrp_channels.sv =====
// Frame request channel
interface wrp_in_if;
	logic valid;
	logic ready;
	logic advance;

	modport source(output valid, output advance, input ready);
	modport sink(input valid, input advance, output ready);
endinterface

// Line segment channel
interface wrp_out_if;
	logic valid;
	logic ready;
	logic signed [wrp_pkg::OUT_X_W-1:0] start_x;
	logic signed [wrp_pkg::OUT_Y_W-1:0] start_y;
	logic signed [wrp_pkg::OUT_X_W-1:0] end_x;
	logic signed [wrp_pkg::OUT_Y_W-1:0] end_y;
	logic last_segment;

	modport source(output valid, output start_x, output start_y, output end_x,
		output end_y, output last_segment, input ready);
	modport sink(input valid, input start_x, input start_y, input end_x,
		input end_y, input last_segment, output ready);
endinterface

// Register write channel
interface wrp_cfg_if;
	logic valid;
	logic ready;
	logic [wrp_pkg::CFG_IDX_W-1:0] index;
	logic [wrp_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/wireframe_rotate_project.sv =====
// Rotating wireframe cube: one frame of line segments per request word.
// Registers are written on the cfg channel (index 0 center_x, 1 center_y,
// 2 half_size); cfg.ready is always high, and writes belong to idle time.
// A word on frame optionally advances the angle by pi/24 and then draws
// the frame: the vertex path is turned about X, Y and Z, projected, and
// VERTEX_COUNT-1 segment words leave on segment, the final one marked with
// last_segment.
// A microprogram of sixteen steps runs one shared multiply-accumulate unit:
// one step loads sine and cosine, then fifteen steps handle each vertex;
// no new request is taken until the sequencer has finished the frame.
// The first segment word is offered once the second vertex is done, and
// each later vertex adds one more.
// frame.ready is high whenever no frame is in progress; the next request
// is taken while the last segment word still waits in the output register.
// If segment stalls, the sequencer holds at its emit step until the output
// register frees up; no word is dropped.
// Reset clears the angle to zero, restores the register defaults and
// empties the output register.
module wireframe_rotate_project #(
	parameter int VERTEX_COUNT = wrp_pkg::VERTEX_COUNT
) (
	input  logic           clk,
	input  logic           arst_n,
	wrp_cfg_if.sink        cfg,
	wrp_in_if.sink         frame,
	wrp_out_if.source      segment
);

	localparam int VTX_W = $clog2(VERTEX_COUNT);

	logic [wrp_pkg::CX_W-1:0] center_x_q;
	logic [wrp_pkg::CY_W-1:0] center_y_q;
	logic [wrp_pkg::HS_W-1:0] half_size_q;
	logic [wrp_pkg::ANG_W-1:0] angle_q;
	logic busy_q;
	logic [wrp_pkg::PC_W-1:0] pc_q;
	logic [VTX_W-1:0] vtx_q;
	logic out_valid_q;

	logic signed [wrp_pkg::OUT_X_W-1:0] prev_x_q;
	logic signed [wrp_pkg::OUT_Y_W-1:0] prev_y_q;
	logic signed [wrp_pkg::OUT_X_W-1:0] start_x_q;
	logic signed [wrp_pkg::OUT_Y_W-1:0] start_y_q;
	logic signed [wrp_pkg::OUT_X_W-1:0] end_x_q;
	logic signed [wrp_pkg::OUT_Y_W-1:0] end_y_q;
	logic last_q;

	wrp_pkg::uword_t ctl;
	logic [3:0] corner_idx;
	logic [2:0] corner_pos;
	logic signed [wrp_pkg::OUT_X_W-1:0] cur_x;
	logic signed [wrp_pkg::OUT_Y_W-1:0] cur_y;
	logic take_frame;
	logic emit_step;
	logic first_vtx;
	logic last_vtx;
	logic out_free;
	logic fire;
	logic vtx_done;

	// Control word of the current step
	assign ctl = busy_q ? wrp_pkg::ucode(pc_q) : wrp_pkg::UW_IDLE;

	// Corner pattern repeats every sixteen vertices
	assign corner_idx = 4'(vtx_q);
	assign corner_pos = {wrp_pkg::CORNER_Z_POS[corner_idx], wrp_pkg::CORNER_Y_POS[corner_idx],
		wrp_pkg::CORNER_X_POS[corner_idx]};

	// Handshake and emit conditions
	assign frame.ready = !busy_q;
	assign cfg.ready = 1'b1;
	assign take_frame = frame.valid && !busy_q;
	assign emit_step = busy_q && (ctl.seq == wrp_pkg::SQ_EMIT);
	assign first_vtx = (vtx_q == '0);
	assign last_vtx = (vtx_q == VTX_W'(VERTEX_COUNT - 1));
	assign out_free = !out_valid_q || segment.ready;
	assign fire = emit_step && !first_vtx && out_free;
	assign vtx_done = emit_step && (first_vtx || out_free);

	wrp_datapath u_dp (
		.clk        (clk),
		.ctl        (ctl),
		.corner_pos (corner_pos),
		.half_size  (half_size_q),
		.center_x   (center_x_q),
		.center_y   (center_y_q),
		.angle      (angle_q),
		.cur_x      (cur_x),
		.cur_y      (cur_y)
	);

	// Registers, angle, sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= wrp_pkg::RST_CENTER_X;
			center_y_q <= wrp_pkg::RST_CENTER_Y;
			half_size_q <= wrp_pkg::RST_HALF_SIZE;
			angle_q <= '0;
			busy_q <= 1'b0;
			pc_q <= wrp_pkg::PC_TRIG;
			vtx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					wrp_pkg::REG_CENTER_X: center_x_q <= cfg.data[wrp_pkg::CX_W-1:0];
					wrp_pkg::REG_CENTER_Y: center_y_q <= cfg.data[wrp_pkg::CY_W-1:0];
					wrp_pkg::REG_HALF_SIZE: half_size_q <= cfg.data[wrp_pkg::HS_W-1:0];
					default: ;
				endcase
			end

			if (take_frame) begin
				busy_q <= 1'b1;
				pc_q <= wrp_pkg::PC_TRIG;
				vtx_q <= '0;
				if (frame.advance) begin
					if (angle_q == wrp_pkg::ANG_W'(wrp_pkg::ANGLE_STEPS - 1)) begin
						angle_q <= '0;
					end else begin
						angle_q <= angle_q + wrp_pkg::ANG_W'(1);
					end
				end
			end else if (busy_q) begin
				if (ctl.seq == wrp_pkg::SQ_NEXT) begin
					pc_q <= pc_q + wrp_pkg::PC_W'(1);
				end else if (vtx_done) begin
					if (fire && last_vtx) begin
						busy_q <= 1'b0;
						pc_q <= wrp_pkg::PC_TRIG;
					end else begin
						vtx_q <= vtx_q + VTX_W'(1);
						pc_q <= wrp_pkg::PC_VTX;
					end
				end
			end

			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (segment.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Previous vertex and the output word
	always_ff @(posedge clk) begin
		if (vtx_done) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (fire) begin
			start_x_q <= prev_x_q;
			start_y_q <= prev_y_q;
			end_x_q <= cur_x;
			end_y_q <= cur_y;
			last_q <= last_vtx;
		end
	end

	assign segment.valid = out_valid_q;
	assign segment.start_x = start_x_q;
	assign segment.start_y = start_y_q;
	assign segment.end_x = end_x_q;
	assign segment.end_y = end_y_q;
	assign segment.last_segment = last_q;

endmodule

// ===== hdl/wrp_datapath.sv =====
// Shared multiply-accumulate datapath driven one control word per cycle.
module wrp_datapath (
	input  logic                                clk,
	input  wrp_pkg::uword_t                     ctl,
	input  logic [2:0]                          corner_pos,
	input  logic [wrp_pkg::HS_W-1:0]            half_size,
	input  logic [wrp_pkg::CX_W-1:0]            center_x,
	input  logic [wrp_pkg::CY_W-1:0]            center_y,
	input  logic [wrp_pkg::ANG_W-1:0]           angle,
	output logic signed [wrp_pkg::OUT_X_W-1:0]  cur_x,
	output logic signed [wrp_pkg::OUT_Y_W-1:0]  cur_y
);

	logic signed [wrp_pkg::COEF_W-1:0] sin_q;
	logic signed [wrp_pkg::COEF_W-1:0] cos_q;
	logic signed [wrp_pkg::YZ_W-1:0] y1_q;
	logic signed [wrp_pkg::YZ_W-1:0] z1_q;
	logic signed [wrp_pkg::OPW-1:0] x2_q;
	logic signed [wrp_pkg::ACC_W-1:0] prod_q;
	logic signed [wrp_pkg::ACC_W-1:0] acc_q;
	logic signed [wrp_pkg::OUT_X_W-1:0] cur_x_q;
	logic signed [wrp_pkg::OUT_Y_W-1:0] cur_y_q;

	logic signed [wrp_pkg::HS_W:0] h_pos;
	logic signed [wrp_pkg::HS_W:0] x0;
	logic signed [wrp_pkg::HS_W:0] y0;
	logic signed [wrp_pkg::HS_W:0] z0;
	logic signed [wrp_pkg::OPW-1:0] a_op;
	logic signed [wrp_pkg::COEF_W-1:0] b_op;
	logic signed [wrp_pkg::ACC_W-1:0] prod_d;

	// Corner coordinates are plus or minus the half size
	assign h_pos = $signed({1'b0, half_size});
	assign x0 = corner_pos[0] ? h_pos : -h_pos;
	assign y0 = corner_pos[1] ? h_pos : -h_pos;
	assign z0 = corner_pos[2] ? h_pos : -h_pos;

	// Multiplier operand selection
	always_comb begin
		case (ctl.msrc)
			wrp_pkg::MS_X0SH: a_op = wrp_pkg::OPW'(x0) <<< wrp_pkg::FRAC;
			wrp_pkg::MS_Y0:   a_op = wrp_pkg::OPW'(y0);
			wrp_pkg::MS_Z0:   a_op = wrp_pkg::OPW'(z0);
			wrp_pkg::MS_Y1SH: a_op = wrp_pkg::OPW'(y1_q) <<< wrp_pkg::FRAC;
			wrp_pkg::MS_Z1:   a_op = wrp_pkg::OPW'(z1_q);
			wrp_pkg::MS_X2:   a_op = x2_q;
			default:          a_op = '0;
		endcase
		b_op = (ctl.coef == wrp_pkg::CF_COS) ? cos_q : sin_q;
		prod_d = a_op * b_op;
	end

	// Product register, then accumulate on the next step
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (ctl.aop)
			wrp_pkg::AO_LOAD: acc_q <= prod_q;
			wrp_pkg::AO_ADD:  acc_q <= acc_q + prod_q;
			wrp_pkg::AO_SUB:  acc_q <= acc_q - prod_q;
			wrp_pkg::AO_RSUB: acc_q <= prod_q - acc_q;
			default:          acc_q <= acc_q;
		endcase
	end

	// Write-back of the accumulator and the trig load
	always_ff @(posedge clk) begin
		case (ctl.wsel)
			wrp_pkg::WS_TRIG: begin
				sin_q <= wrp_pkg::sin_q15(angle);
				cos_q <= wrp_pkg::sin_q15(wrp_pkg::cos_index(angle));
			end
			wrp_pkg::WS_Y1: y1_q <= acc_q[wrp_pkg::YZ_W-1:0];
			wrp_pkg::WS_Z1: z1_q <= acc_q[wrp_pkg::YZ_W-1:0];
			wrp_pkg::WS_X2: x2_q <= acc_q[wrp_pkg::OPW-1:0];
			// Floor by dropping the fraction, then wrap to the field width
			wrp_pkg::WS_X3: cur_x_q <= $signed(acc_q[wrp_pkg::ACC_SHIFT +: wrp_pkg::OUT_X_W]
				+ {{(wrp_pkg::OUT_X_W - wrp_pkg::CX_W){1'b0}}, center_x});
			wrp_pkg::WS_Y3: cur_y_q <= $signed(acc_q[wrp_pkg::ACC_SHIFT +: wrp_pkg::OUT_Y_W]
				+ {{(wrp_pkg::OUT_Y_W - wrp_pkg::CY_W){1'b0}}, center_y});
			default: ;
		endcase
	end

	assign cur_x = cur_x_q;
	assign cur_y = cur_y_q;

endmodule

// ===== bench/wrp_segment_checker.sv =====
`timescale 1ns / 100ps
module wrp_segment_checker (
	input  logic clk,
	input  logic arst_n,
	wrp_cfg_if   cfg,
	wrp_in_if    frame,
	wrp_out_if   segment,
	output int   mismatches,
	output int   words_due,
	output int   frames_seen,
	output int   words_seen,
	output int   angles_hit
);

	// One segment word as it leaves the block
	typedef struct packed {
		logic signed [wrp_pkg::OUT_X_W-1:0] start_x;
		logic signed [wrp_pkg::OUT_Y_W-1:0] start_y;
		logic signed [wrp_pkg::OUT_X_W-1:0] end_x;
		logic signed [wrp_pkg::OUT_Y_W-1:0] end_y;
		logic                               last_segment;
	} seg_word_t;

	localparam longint TWO_PI_Q28 = 64'sd1686629713;
	localparam longint ONE_Q28 = 64'sd1 << 28;

	// Corner signs of the vertex path, one entry per vertex of the pattern
	localparam int CORNER_SX [16] = '{-1, 1, 1, -1, -1, -1, 1, 1, 1, 1, 1, -1, -1, -1, -1, 1};
	localparam int CORNER_SY [16] = '{1, 1, 1, 1, 1, -1, -1, 1, 1, -1, -1, -1, -1, 1, -1, -1};
	localparam int CORNER_SZ [16] = '{1, 1, -1, -1, 1, 1, 1, 1, -1, -1, 1, 1, -1, -1, -1, -1};

	logic [wrp_pkg::CX_W-1:0]  center_x;
	logic [wrp_pkg::CY_W-1:0]  center_y;
	logic [wrp_pkg::HS_W-1:0]  half_size;
	logic [wrp_pkg::ANG_W-1:0] angle_idx;
	logic [wrp_pkg::ANGLE_STEPS-1:0] angle_hit;
	seg_word_t segments_due[$];

	// Round a Q28 value to Q15, halves away from zero.
	function automatic longint q28_round(input longint v);
		if (v < 0) begin
			return -((-v + 4096) / 8192);
		end
		return (v + 4096) / 8192;
	endfunction

	// Sine and cosine of the angle step at scale 2^15, from a Taylor series in Q28.
	function automatic void angle_trig(input int k, output longint sin_q15,
			output longint cos_q15);
		longint kk, x, ts, tc, ss, cc;
		kk = longint'(k % wrp_pkg::ANGLE_STEPS);
		if (kk > wrp_pkg::ANGLE_STEPS / 2) begin
			kk = kk - wrp_pkg::ANGLE_STEPS;
		end
		x = TWO_PI_Q28 * kk / wrp_pkg::ANGLE_STEPS;
		ts = x;
		ss = x;
		tc = ONE_Q28;
		cc = ONE_Q28;
		for (int n = 1; n <= 11; n++) begin
			ts = ts * x / ONE_Q28;
			ts = ts * x / ONE_Q28;
			ts = -ts / (longint'(2 * n) * longint'(2 * n + 1));
			ss = ss + ts;
			tc = tc * x / ONE_Q28;
			tc = tc * x / ONE_Q28;
			tc = -tc / (longint'(2 * n - 1) * longint'(2 * n));
			cc = cc + tc;
		end
		sin_q15 = q28_round(ss);
		cos_q15 = q28_round(cc);
	endfunction

	// Rotate the path about X, Y and Z, project, and queue the frame's segments.
	function automatic void predict_frame();
		longint s, c, h;
		longint x0, y0, z0, x1, y1, z1, x2, y2, x3, y3;
		longint px [wrp_pkg::VERTEX_COUNT];
		longint py [wrp_pkg::VERTEX_COUNT];
		seg_word_t w;
		angle_trig(int'(angle_idx), s, c);
		h = longint'(half_size);
		for (int i = 0; i < wrp_pkg::VERTEX_COUNT; i++) begin
			x0 = h * CORNER_SX[i % 16];
			y0 = h * CORNER_SY[i % 16];
			z0 = h * CORNER_SZ[i % 16];
			x1 = x0 * 32768;
			y1 = y0 * c - z0 * s;
			z1 = y0 * s + z0 * c;
			x2 = x1 * c + z1 * s;
			y2 = y1 * 32768;
			x3 = x2 * c - y2 * s;
			y3 = x2 * s + y2 * c;
			// Arithmetic shift floors toward minus infinity.
			px[i] = (x3 >>> wrp_pkg::ACC_SHIFT) + longint'(center_x);
			py[i] = (y3 >>> wrp_pkg::ACC_SHIFT) + longint'(center_y);
		end
		for (int i = 0; i < wrp_pkg::VERTEX_COUNT - 1; i++) begin
			w.start_x = px[i][wrp_pkg::OUT_X_W-1:0];
			w.start_y = py[i][wrp_pkg::OUT_Y_W-1:0];
			w.end_x = px[i+1][wrp_pkg::OUT_X_W-1:0];
			w.end_y = py[i+1][wrp_pkg::OUT_Y_W-1:0];
			w.last_segment = (i == wrp_pkg::VERTEX_COUNT - 2);
			segments_due.push_back(w);
		end
	endfunction

	// Track registers and angle, predict frames and compare segment words.
	always @(posedge clk or negedge arst_n) begin
		seg_word_t want;
		seg_word_t got;
		if (!arst_n) begin
			center_x = wrp_pkg::RST_CENTER_X;
			center_y = wrp_pkg::RST_CENTER_Y;
			half_size = wrp_pkg::RST_HALF_SIZE;
			angle_idx = '0;
			angle_hit = '0;
			segments_due.delete();
			mismatches = 0;
			words_due = 0;
			frames_seen = 0;
			words_seen = 0;
			angles_hit = 0;
		end else begin
			// Results are matched before this edge's frame adds new ones.
			if (segment.valid && segment.ready) begin
				got = '{segment.start_x, segment.start_y, segment.end_x, segment.end_y,
					segment.last_segment};
				words_seen++;
				if (segments_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: word with none expected: (%0d,%0d)-(%0d,%0d) last=%0b",
							$realtime, got.start_x, got.start_y, got.end_x, got.end_y,
							got.last_segment);
					end
				end else begin
					want = segments_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected (%0d,%0d)-(%0d,%0d) last=%0b",
								$realtime, want.start_x, want.start_y, want.end_x,
								want.end_y, want.last_segment);
							$display("%0t: got      (%0d,%0d)-(%0d,%0d) last=%0b",
								$realtime, got.start_x, got.start_y, got.end_x,
								got.end_y, got.last_segment);
						end
					end
				end
			end
			// Register writes are masked to each register's width.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					wrp_pkg::REG_CENTER_X: center_x = cfg.data[wrp_pkg::CX_W-1:0];
					wrp_pkg::REG_CENTER_Y: center_y = cfg.data[wrp_pkg::CY_W-1:0];
					wrp_pkg::REG_HALF_SIZE: half_size = cfg.data[wrp_pkg::HS_W-1:0];
					default: ;
				endcase
			end
			// A frame request may step the angle before it is drawn.
			if (frame.valid && frame.ready) begin
				if (frame.advance) begin
					if (angle_idx == wrp_pkg::ANG_W'(wrp_pkg::ANGLE_STEPS - 1)) begin
						angle_idx = '0;
					end else begin
						angle_idx = angle_idx + wrp_pkg::ANG_W'(1);
					end
				end
				angle_hit[angle_idx] = 1'b1;
				angles_hit = $countones(angle_hit);
				frames_seen++;
				predict_frame();
			end
			words_due = segments_due.size();
		end
	end

endmodule

// ===== bench/tb_wireframe_rotate_project.sv =====
`timescale 1ns / 100ps
module tb_wireframe_rotate_project;

	// Index with no register behind it; writes to it are ignored.
	localparam logic [wrp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_FRAMES = 100;

	logic clk;
	logic arst_n;
	bit   calm;
	int   reg_writes;
	int   check_errors;
	int   words_due;
	int   frames_seen;
	int   words_seen;
	int   angles_hit;

	wrp_cfg_if cfg_if();
	wrp_in_if  frame_if();
	wrp_out_if seg_if();

	wireframe_rotate_project DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.frame(frame_if),
		.segment(seg_if)
	);

	wrp_segment_checker segment_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.frame(frame_if),
		.segment(seg_if),
		.mismatches(check_errors),
		.words_due(words_due),
		.frames_seen(frames_seen),
		.words_seen(words_seen),
		.angles_hit(angles_hit)
	);

	// 50 MHz clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver stalls now and then, except during the calm stretch.
	always @(negedge clk) begin
		seg_if.ready <= calm || ($urandom_range(99) >= 21);
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("tb_wireframe_rotate_project NOT OK");
		$finish;
	end

	// Offer one frame request and hold it until taken, then maybe idle.
	task automatic send_frame(input logic adv);
		@(negedge clk);
		frame_if.valid <= 1'b1;
		frame_if.advance <= adv;
		@(posedge clk);
		while (!frame_if.ready) @(posedge clk);
		if (!calm && $urandom_range(99) < 21) begin
			@(negedge clk);
			frame_if.valid <= 1'b0;
			frame_if.advance <= 1'($urandom_range(1));
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
	endtask

	// Stop requesting and wait until every segment word has come back.
	task automatic drain_frames();
		@(negedge clk);
		frame_if.valid <= 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [wrp_pkg::CFG_IDX_W-1:0] idx,
			input logic [wrp_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		reg_writes++;
	endtask

	// Register value: often an extreme, otherwise anything the data word holds.
	function automatic logic [wrp_pkg::CFG_DATA_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return wrp_pkg::CFG_DATA_W'($urandom);
		endcase
	endfunction

	initial begin
		int random_sent;
		int n;
		arst_n = 1'b0;
		calm = 1'b0;
		reg_writes = 0;
		cfg_if.valid = 1'b0;
		cfg_if.index = wrp_pkg::REG_CENTER_X;
		cfg_if.data = '0;
		frame_if.valid = 1'b0;
		frame_if.advance = 1'b0;
		seg_if.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: angle zero held, then stepped.
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b1);
		send_frame(1'b0);
		drain_frames();

		// Zero half size collapses every segment onto the center.
		write_reg(wrp_pkg::REG_CENTER_X, '0);
		write_reg(wrp_pkg::REG_CENTER_Y, '0);
		write_reg(wrp_pkg::REG_HALF_SIZE, '0);
		send_frame(1'b1);
		send_frame(1'b0);
		drain_frames();

		// Largest cube at the far corner wraps the output fields.
		write_reg(wrp_pkg::REG_CENTER_X, 7'd127);
		write_reg(wrp_pkg::REG_CENTER_Y, 7'd63);
		write_reg(wrp_pkg::REG_HALF_SIZE, 7'd63);
		send_frame(1'b1);
		send_frame(1'b1);
		send_frame(1'b1);
		drain_frames();

		// Upper data bits are dropped for the narrow registers; the spare index
		// must leave everything alone.
		write_reg(wrp_pkg::REG_CENTER_X, 7'h55);
		write_reg(wrp_pkg::REG_CENTER_Y, 7'h7F);
		write_reg(wrp_pkg::REG_HALF_SIZE, 7'h41);
		write_reg(REG_SPARE, 7'h2A);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b1);
		drain_frames();

		// Random phases, each with fresh settings.
		random_sent = 0;
		for (int phase = 0; random_sent < RANDOM_FRAMES; phase++) begin
			write_reg(wrp_pkg::REG_CENTER_X, pick_value());
			write_reg(wrp_pkg::REG_CENTER_Y, pick_value());
			write_reg(wrp_pkg::REG_HALF_SIZE, pick_value());
			if ($urandom_range(3) == 0) begin
				write_reg(REG_SPARE, pick_value());
			end
			calm = (phase == 2);
			n = $urandom_range(15, 10);
			for (int j = 0; j < n; j++) begin
				// Once, let the block empty out completely mid-phase.
				if (phase == 4 && j == n / 2) begin
					drain_frames();
				end
				send_frame($urandom_range(99) < 85);
				random_sent++;
			end
			drain_frames();
			calm = 1'b0;
		end

		// Allow for any word the block might still produce.
		repeat (300) @(negedge clk);
		$display("Sent %0d frame requests and %0d register writes under reset,",
			frames_seen, reg_writes);
		$display("zero, extreme and random settings; checked %0d words, %0d of %0d angles.",
			words_seen, angles_hit, wrp_pkg::ANGLE_STEPS);
		if (check_errors == 0 && words_due == 0) begin
			$display("tb_wireframe_rotate_project OK");
		end else begin
			$display("tb_wireframe_rotate_project NOT OK");
		end
		$finish;
	end

endmodule
